### rtl/nwua_pkg.sv
// Package for the neuron weight-update / activate block.
// Holds widths, operation and register codes, FSM states and the sigmoid table.
// No dependencies.
package nwua_pkg;

    // Sizes
    localparam int MAX_INPUTS     = 16;
    localparam int POS_W          = $clog2(MAX_INPUTS);
    localparam int CNT_W          = 5;
    localparam int WEIGHT_BITS    = 16;
    localparam int VALUE_W        = 16;
    localparam int PROD_W         = 32;
    localparam int SUM_W          = 40;
    localparam int ACT_W          = 16;
    localparam int EPS_W          = 16;

    // Sigmoid table: entry i stands for x = i * 8 / SIG_DEPTH
    localparam int SIG_TABLE_BITS = 8;
    localparam int SIG_DEPTH      = 1 << SIG_TABLE_BITS;
    localparam int SIG_RANGE_BIT  = 27;
    localparam int SIG_SHIFT      = SIG_RANGE_BIT - SIG_TABLE_BITS;

    localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_RESET = 16'sd2048;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SET   = 2'd1,
        OP_INPUT = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_INPUTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_EPSILON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_EPSILON = 2'd2;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STEP,
        ST_SIGGO,
        ST_SIG,
        ST_OUT
    } state_t;

    // Weight memory access request
    typedef struct packed {
        logic                          rd_en;
        logic [POS_W-1:0]              rd_addr;
        logic                          wr_en;
        logic [POS_W-1:0]              wr_addr;
        logic signed [WEIGHT_BITS-1:0] wr_data;
    } wram_req_t;

    typedef logic [ACT_W-1:0] sig_table_t [SIG_DEPTH];

    // Unsigned 64-bit quotient by shift and subtract, table build only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, dvs})
            begin
                rem    = rem - {1'b0, dvs};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One sigmoid entry, fixed-point exp(-x) by series plus powers of 1/e (Q30).
    // Evaluated only at elaboration to build the constant table.
    function automatic logic [ACT_W-1:0] sig_entry(input int unsigned idx);
        logic [63:0] k;
        logic [63:0] frac;
        logic [63:0] fq;
        logic [63:0] term;
        logic [63:0] pos_acc;
        logic [63:0] neg_acc;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] r;
        k       = 64'(idx) >> (SIG_TABLE_BITS - 3);
        frac    = (64'(idx) << 3) & ((64'd1 << SIG_TABLE_BITS) - 64'd1);
        fq      = frac << (30 - SIG_TABLE_BITS);
        term    = 64'd1 << 30;
        pos_acc = 64'd1 << 30;
        neg_acc = 64'd0;
        for (int n = 1; n <= 24; n++)
        begin
            term = udiv64((term * fq) >> 30, 64'(n));
            if ((n & 1) == 1)
            begin
                neg_acc = neg_acc + term;
            end
            else
            begin
                pos_acc = pos_acc + term;
            end
        end
        e = pos_acc - neg_acc;
        for (int j = 0; j < 8; j++)
        begin
            if (64'(j) < k)
            begin
                e = (e * 64'd395007542) >> 30;
            end
        end
        den = (64'd1 << 30) + e;
        r   = udiv64((64'd1 << 46) + (den >> 1), den);
        return (r > 64'd65535) ? 16'hFFFF : r[ACT_W-1:0];
    endfunction

    function automatic sig_table_t build_sig_table();
        sig_table_t t;
        for (int i = 0; i < SIG_DEPTH; i++)
        begin
            t[i] = sig_entry(i);
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

### rtl/nwua_weight_ram.sv
// Weight memory: 16 x 16 synchronous RAM with a registered read.
// Per-entry valid bits make unwritten entries read as the reset weight.
// Depends on nwua_pkg.
module nwua_weight_ram
    import nwua_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wram_req_t                     req,
    output logic signed [WEIGHT_BITS-1:0] rd_data
);

    logic signed [WEIGHT_BITS-1:0] mem_array [MAX_INPUTS];
    logic [MAX_INPUTS-1:0]         valid_reg;
    logic signed [WEIGHT_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    // Storage and read data path
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem_array[req.rd_addr];
        end
    end

    // Entry valid bits, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : WEIGHT_RESET;

endmodule

### rtl/nwua_sigmoid.sv
// Two-stage table sigmoid: signed Q16.24 sum in, unsigned Q0.16 activation out.
// Stage 1 takes magnitude, index and range flag, stage 2 looks up the table and mirrors negative sums.
// Depends on nwua_pkg (SIG_TABLE).
module nwua_sigmoid
    import nwua_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] sum,
    output logic                    done,
    output logic [ACT_W-1:0]        act
);

    logic [SUM_W-1:0]          mag;
    logic [SIG_TABLE_BITS-1:0] idx_reg;
    logic                      over_reg;
    logic                      neg_reg;
    logic                      s1_valid_reg;
    logic                      done_reg;
    logic [ACT_W-1:0]          act_reg;
    logic [ACT_W-1:0]          entry;
    logic [ACT_W:0]            mirrored;

    // Stage 1: magnitude, table index, out-of-range flag
    assign mag = sum[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum)) : SUM_W'(sum);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg  <= mag[SIG_SHIFT +: SIG_TABLE_BITS];
            over_reg <= |mag[SUM_W-1:SIG_RANGE_BIT];
            neg_reg  <= sum[SUM_W-1];
        end
    end

    // Stage 2: lookup, mirror for negative sums
    assign entry    = over_reg ? {ACT_W{1'b1}} : SIG_TABLE[idx_reg];
    assign mirrored = (ACT_W+1)'(1 << ACT_W) - {1'b0, entry};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            act_reg <= neg_reg ? mirrored[ACT_W-1:0] : entry;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            done_reg     <= s1_valid_reg;
        end
    end

    assign done = done_reg;
    assign act  = act_reg;

endmodule

### rtl/neuron_weight_update_activate_top.sv
// Neuron weight update / activate, top level. Depends on nwua_pkg, nwua_weight_ram, nwua_sigmoid.
// Each item of a vector passes read, execute and step on the weight RAM before the next is taken;
// the last item then goes to the output state, through the 2-stage sigmoid for an input vector.
// Result: loaded into the output slot once the slot is free (the output state waits for it),
// held until taken. Reset (rst_n, async, active low): weights read as 0.5 via per-entry
// valid bits, flags, output and sum cleared, active_inputs = 1, eps = 0.
module neuron_weight_update_activate_top
    import nwua_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                operation,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ACT_W-1:0]          activation,
    output logic                      weights_stagnated,
    output logic                      output_stagnated,
    output logic [1:0]                finished_operation
);

    // Configuration
    logic [CNT_W-1:0] active_inputs_reg;
    logic [EPS_W-1:0] weight_eps_reg;
    logic [EPS_W-1:0] output_eps_reg;

    // Control and datapath state
    state_t                        state_reg, state_next;
    op_t                           op_reg;
    logic signed [VALUE_W-1:0]     value_reg;
    logic [POS_W-1:0]              pos_reg, pos_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [SUM_W-1:0]       sum_reg, sum_next;
    logic                          change_reg, change_next;
    logic [ACT_W-1:0]              cur_out_reg, cur_out_next;
    logic                          wflag_reg, wflag_next;
    logic                          oflag_reg, oflag_next;
    logic                          out_valid_reg, out_valid_next;
    logic [ACT_W-1:0]              out_act_reg;
    logic                          out_wstag_reg;
    logic                          out_ostag_reg;
    op_t                           out_op_reg;

    logic                          accept;
    logic                          out_load;
    logic                          slot_free;
    wram_req_t                     wram_req;
    logic signed [WEIGHT_BITS-1:0] rd_weight;
    logic signed [WEIGHT_BITS:0]   add_sum;
    logic signed [WEIGHT_BITS-1:0] new_weight;
    logic signed [WEIGHT_BITS:0]   delta;
    logic [WEIGHT_BITS:0]          delta_abs;
    logic [CNT_W-1:0]              count;
    logic                          last_elem;
    logic                          sig_start;
    logic                          sig_done;
    logic [ACT_W-1:0]              sig_act;
    logic [ACT_W-1:0]              act_diff;

    // Weight memory and sigmoid unit
    nwua_weight_ram u_wram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (wram_req),
        .rd_data (rd_weight)
    );

    nwua_sigmoid u_sig (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sig_start),
        .sum   (sum_reg),
        .done  (sig_done),
        .act   (sig_act)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_inputs_reg <= CNT_W'(1);
            weight_eps_reg    <= '0;
            output_eps_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_INPUTS:  active_inputs_reg <= cfg_data[CNT_W-1:0];
                CFG_WEIGHT_EPSILON: weight_eps_reg    <= cfg_data[EPS_W-1:0];
                CFG_OUTPUT_EPSILON: output_eps_reg    <= cfg_data[EPS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Effective vector length and last-element test
    always_comb
    begin
        if (active_inputs_reg == '0)
        begin
            count = CNT_W'(1);
        end
        else if (active_inputs_reg > CNT_W'(MAX_INPUTS))
        begin
            count = CNT_W'(MAX_INPUTS);
        end
        else
        begin
            count = active_inputs_reg;
        end
    end

    assign last_elem = ({1'b0, pos_reg} + CNT_W'(1)) >= count;

    // Weight update arithmetic, saturating to the weight range
    assign add_sum = {rd_weight[WEIGHT_BITS-1], rd_weight} + {value_reg[VALUE_W-1], value_reg};

    always_comb
    begin
        if (op_reg == OP_SET)
        begin
            new_weight = value_reg;
        end
        else if (add_sum[WEIGHT_BITS] != add_sum[WEIGHT_BITS-1])
        begin
            new_weight = add_sum[WEIGHT_BITS] ? {1'b1, {(WEIGHT_BITS-1){1'b0}}}
                                              : {1'b0, {(WEIGHT_BITS-1){1'b1}}};
        end
        else
        begin
            new_weight = add_sum[WEIGHT_BITS-1:0];
        end
    end

    assign delta     = {new_weight[WEIGHT_BITS-1], new_weight}
                     - {rd_weight[WEIGHT_BITS-1], rd_weight};
    assign delta_abs = delta[WEIGHT_BITS] ? ((WEIGHT_BITS+1)'(0) - delta) : delta;

    assign act_diff  = (sig_act > cur_out_reg) ? (sig_act - cur_out_reg)
                                               : (cur_out_reg - sig_act);

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        change_next    = change_reg;
        cur_out_next   = cur_out_reg;
        wflag_next     = wflag_reg;
        oflag_next     = oflag_reg;
        in_ready       = 1'b0;
        sig_start      = 1'b0;
        out_load       = 1'b0;
        wram_req       = '0;
        wram_req.rd_addr = pos_reg;
        wram_req.wr_addr = pos_reg;
        wram_req.wr_data = new_weight;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (op_t'(operation) != OP_NONE))
                begin
                    wram_req.rd_en = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_INPUT)
                begin
                    prod_next = rd_weight * value_reg;
                end
                else
                begin
                    wram_req.wr_en = 1'b1;
                    if (delta_abs > {1'b0, weight_eps_reg})
                    begin
                        change_next = 1'b1;
                    end
                end
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (op_reg == OP_INPUT)
                begin
                    sum_next = sum_reg + SUM_W'(prod_reg);
                end
                if (!last_elem)
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = ST_IDLE;
                end
                else if (op_reg == OP_INPUT)
                begin
                    state_next = ST_SIGGO;
                end
                else
                begin
                    wflag_next = !change_reg;
                    state_next = ST_OUT;
                end
            end
            ST_SIGGO:
            begin
                sig_start  = 1'b1;
                state_next = ST_SIG;
            end
            ST_SIG:
            begin
                if (sig_done)
                begin
                    cur_out_next = sig_act;
                    oflag_next   = act_diff <= output_eps_reg;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    pos_next    = '0;
                    sum_next    = '0;
                    change_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output slot handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            sum_reg       <= '0;
            change_reg    <= 1'b0;
            cur_out_reg   <= '0;
            wflag_reg     <= 1'b0;
            oflag_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            change_reg    <= change_next;
            cur_out_reg   <= cur_out_next;
            wflag_reg     <= wflag_next;
            oflag_reg     <= oflag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (accept)
        begin
            op_reg    <= op_t'(operation);
            value_reg <= value;
        end
        if (out_load)
        begin
            out_act_reg   <= cur_out_reg;
            out_wstag_reg <= wflag_reg;
            out_ostag_reg <= oflag_reg;
            out_op_reg    <= op_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign activation         = out_act_reg;
    assign weights_stagnated  = out_wstag_reg;
    assign output_stagnated   = out_ostag_reg;
    assign finished_operation = out_op_reg;

`ifndef NO_ASSERTIONS
    // A new result only appears out of the output state
    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    // Weight writes happen only while executing a weight element
    a_write_only_weight_op: assert property (@(posedge clk) disable iff (!rst_n)
        wram_req.wr_en |-> (state_reg == ST_EXEC && op_reg != OP_INPUT))
        else $error("weight write outside weight update");

    // Sigmoid results arrive only while the sequencer waits for them
    a_sig_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sig_done |-> state_reg == ST_SIG)
        else $error("sigmoid result while not waiting");

    // At the start of a vector the accumulator is clear
    a_sum_clear_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && pos_reg == '0) |-> sum_reg == '0)
        else $error("accumulator not clear at vector start");

    // A full output slot is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");
`endif

endmodule
